>>> design/rrb_pkg.sv
// Shared constants for the record ring buffer: field widths, action and status codes.
package rrb_pkg;

	// field widths
	localparam int ACT_W  = 2;
	localparam int STAT_W = 2;
	localparam int BYTE_W = 8;
	localparam int LEN_W  = 12;
	localparam int OFF_W  = 13;

	// record header: one type byte, then a 4-byte little-endian length
	localparam int HDR_BYTES = 5;
	localparam int HDR_CNT_W = 3;

	// action codes
	localparam logic [ACT_W-1:0] ACT_BEGIN = 2'd0;
	localparam logic [ACT_W-1:0] ACT_WRITE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_TOO_LARGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd2;
	localparam logic [STAT_W-1:0] ST_BAD_STATE = 2'd3;

endpackage

>>> design/rrb_wrap_add.sv
// Shared address unit: adds an offset to a ring pointer and wraps it modulo DEPTH.
module rrb_wrap_add #(
	parameter int DEPTH = 4096,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic [AW-1:0]             base,
	input  logic [rrb_pkg::OFF_W-1:0] offset,
	output logic [AW-1:0]             sum
);

	localparam int SW = ((AW > rrb_pkg::OFF_W) ? AW : rrb_pkg::OFF_W) + 1;
	localparam logic [SW-1:0] DEPTH_C = SW'(DEPTH);

	logic [SW-1:0] raw;
	logic [SW-1:0] wrapped;

	// add, then fold back once past the end of the ring
	always_comb begin
		raw     = SW'(base) + SW'(offset);
		wrapped = (raw >= DEPTH_C) ? (raw - DEPTH_C) : raw;
		sum     = wrapped[AW-1:0];
	end

endmodule

>>> design/record_ring_buffer_drop_oldest.sv
// Top level: byte ring buffer of variable-length records that drops the oldest to make room.
//
//   channel | signals                                        | handshake
//   --------+------------------------------------------------+-------------------
//   in      | action, rec_type, rec_len, data_byte           | in_valid/in_ready
//   out     | status, out_byte, out_type, out_len, out_last, | out_valid/out_ready
//           | dropped, is_empty                              |
//
// One word at a time runs through a small sequencer around one wrap-around address adder
// and a byte store with one write and one registered read per cycle.
// Each word steps through idle, execute and finish; a read of a non-empty ring adds
// type, length and data fetches, and an accepted begin adds an eviction check, two
// length fetches per evicted record and one header write per header byte. The steps
// run in turn, as every header byte passes through the adder and the store's one read port.
// Reset clears the pointers and flags; the byte store is not cleared.
// A waiting result does not block the next accept; that word holds in its last step
// until the output register is free.
module record_ring_buffer_drop_oldest #(
	parameter int DEPTH = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [rrb_pkg::ACT_W-1:0]  action,
	input  logic [rrb_pkg::BYTE_W-1:0] rec_type,
	input  logic [rrb_pkg::LEN_W-1:0]  rec_len,
	input  logic [rrb_pkg::BYTE_W-1:0] data_byte,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [rrb_pkg::STAT_W-1:0] status,
	output logic [rrb_pkg::BYTE_W-1:0] out_byte,
	output logic [rrb_pkg::BYTE_W-1:0] out_type,
	output logic [rrb_pkg::LEN_W-1:0]  out_len,
	output logic                       out_last,
	output logic                       dropped,
	output logic                       is_empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int OW = rrb_pkg::OFF_W;
	localparam int LW = rrb_pkg::LEN_W;
	localparam int BW = rrb_pkg::BYTE_W;
	localparam int KW = rrb_pkg::HDR_CNT_W;
	localparam int CW = ((AW > OW) ? AW : OW) + 2;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [OW-1:0] HDR_C   = OW'(rrb_pkg::HDR_BYTES);
	localparam logic [KW-1:0] HDR_END_K = KW'(rrb_pkg::HDR_BYTES - 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_EV_CHECK,
		S_EV_LO,
		S_EV_HI,
		S_HDR,
		S_HDR_END,
		S_RD_T,
		S_RD_L,
		S_RD_H,
		S_RD_D,
		S_FINISH
	} state_t;

	state_t state_q;

	// ring pointers and record bookkeeping
	logic [AW-1:0] head_q;
	logic [AW-1:0] commit_q;
	logic [AW-1:0] fill_q;
	logic [LW-1:0] rd_off_q;
	logic [LW-1:0] pend_q;
	logic          open_q;

	// latched input word
	logic [rrb_pkg::ACT_W-1:0] act_q;
	logic [BW-1:0]             type_q;
	logic [LW-1:0]             len_q;
	logic [BW-1:0]             dbyte_q;

	// working registers
	logic [KW-1:0] k_q;
	logic [BW-1:0] lenlo_q;

	// result being built
	logic [rrb_pkg::STAT_W-1:0] res_status_q;
	logic [BW-1:0]              res_byte_q;
	logic [BW-1:0]              res_type_q;
	logic [LW-1:0]              res_len_q;
	logic                       res_last_q;
	logic                       res_drop_q;

	// output register
	logic                       out_valid_q;
	logic [rrb_pkg::STAT_W-1:0] status_q;
	logic [BW-1:0]              out_byte_q;
	logic [BW-1:0]              out_type_q;
	logic [LW-1:0]              out_len_q;
	logic                       out_last_q;
	logic                       dropped_q;
	logic                       is_empty_q;

	// byte store
	logic [BW-1:0] mem [DEPTH];
	logic [BW-1:0] rd_data_q;

	// shared adder and store controls
	logic [AW-1:0] add_base;
	logic [OW-1:0] add_off;
	logic [AW-1:0] add_sum;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [BW-1:0] wr_data;

	// occupancy and fit checks
	logic [CW-1:0] used;
	logic [OW-1:0] total;
	logic          too_large;
	logic          no_fit;
	logic [LW-1:0] len_ev;
	logic          rd_more;
	logic [LW-1:0] off_next;

	rrb_wrap_add #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_wrap_add (
		.base   (add_base),
		.offset (add_off),
		.sum    (add_sum)
	);

	// occupancy, record size and read progress
	always_comb begin
		used      = (commit_q >= head_q) ? (CW'(commit_q) - CW'(head_q))
		                                 : (CW'(commit_q) + DEPTH_C - CW'(head_q));
		total     = OW'(len_q) + HDR_C;
		too_large = (CW'(total) + CW'(1)) >= DEPTH_C;
		no_fit    = (used + CW'(total) + CW'(1)) >= DEPTH_C;
		len_ev    = {rd_data_q[3:0], lenlo_q};
		rd_more   = rd_off_q < res_len_q;
		off_next  = rd_more ? (rd_off_q + LW'(1)) : rd_off_q;
	end

	// steer the adder and the store by sequencer step
	always_comb begin
		add_base = head_q;
		add_off  = '0;
		wr_en    = 1'b0;
		wr_addr  = fill_q;
		wr_data  = dbyte_q;
		case (state_q)
			S_EXEC: begin
				if (act_q == rrb_pkg::ACT_WRITE) begin
					add_base = fill_q;
					add_off  = OW'(1);
					wr_en    = open_q;
				end
			end
			S_EV_CHECK: add_off = OW'(1);
			S_EV_LO:    add_off = OW'(2);
			S_EV_HI:    add_off = HDR_C + OW'(len_ev);
			S_HDR: begin
				add_base = commit_q;
				add_off  = OW'(k_q);
				wr_en    = 1'b1;
				wr_addr  = add_sum;
				case (k_q)
					KW'(0):  wr_data = type_q;
					KW'(1):  wr_data = len_q[7:0];
					KW'(2):  wr_data = {4'b0000, len_q[LW-1:8]};
					default: wr_data = '0;
				endcase
			end
			S_HDR_END: begin
				add_base = commit_q;
				add_off  = HDR_C;
			end
			S_RD_T: add_off = OW'(1);
			S_RD_L: add_off = OW'(2);
			S_RD_H: add_off = HDR_C + OW'(rd_off_q);
			S_RD_D: add_off = HDR_C + OW'(res_len_q);
			default: ;
		endcase
	end

	// byte store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[add_sum];
	end

	// sequencer, pointers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= '0;
			commit_q     <= '0;
			fill_q       <= '0;
			rd_off_q     <= '0;
			pend_q       <= '0;
			open_q       <= 1'b0;
			act_q        <= '0;
			type_q       <= '0;
			len_q        <= '0;
			dbyte_q      <= '0;
			k_q          <= '0;
			lenlo_q      <= '0;
			res_status_q <= rrb_pkg::ST_OK;
			res_byte_q   <= '0;
			res_type_q   <= '0;
			res_len_q    <= '0;
			res_last_q   <= 1'b0;
			res_drop_q   <= 1'b0;
			out_valid_q  <= 1'b0;
			status_q     <= rrb_pkg::ST_OK;
			out_byte_q   <= '0;
			out_type_q   <= '0;
			out_len_q    <= '0;
			out_last_q   <= 1'b0;
			dropped_q    <= 1'b0;
			is_empty_q   <= 1'b0;
		end else begin
			// drop the result once taken, unless a new one replaces it
			if (out_valid_q && out_ready && (state_q != S_FINISH)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						act_q        <= action;
						type_q       <= rec_type;
						len_q        <= rec_len;
						dbyte_q      <= data_byte;
						res_status_q <= rrb_pkg::ST_OK;
						res_byte_q   <= '0;
						res_type_q   <= '0;
						res_len_q    <= '0;
						res_last_q   <= 1'b0;
						res_drop_q   <= 1'b0;
						state_q      <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (act_q)
						rrb_pkg::ACT_BEGIN: begin
							if (open_q) begin
								res_status_q <= rrb_pkg::ST_BAD_STATE;
								state_q      <= S_FINISH;
							end else if (too_large) begin
								res_status_q <= rrb_pkg::ST_TOO_LARGE;
								state_q      <= S_FINISH;
							end else begin
								state_q <= S_EV_CHECK;
							end
						end
						rrb_pkg::ACT_WRITE: begin
							if (!open_q) begin
								res_status_q <= rrb_pkg::ST_BAD_STATE;
							end else begin
								fill_q <= add_sum;
								pend_q <= pend_q - LW'(1);
								if (pend_q == LW'(1)) begin
									commit_q <= add_sum;
									open_q   <= 1'b0;
								end
							end
							state_q <= S_FINISH;
						end
						rrb_pkg::ACT_READ: begin
							if (head_q == commit_q) begin
								res_status_q <= rrb_pkg::ST_EMPTY;
								state_q      <= S_FINISH;
							end else begin
								state_q <= S_RD_T;
							end
						end
						default: begin
							res_status_q <= rrb_pkg::ST_BAD_STATE;
							state_q      <= S_FINISH;
						end
					endcase
				end
				// evict oldest records until the new one fits
				S_EV_CHECK: begin
					if ((head_q != commit_q) && no_fit) begin
						state_q <= S_EV_LO;
					end else begin
						k_q     <= '0;
						state_q <= S_HDR;
					end
				end
				S_EV_LO: begin
					lenlo_q <= rd_data_q;
					state_q <= S_EV_HI;
				end
				S_EV_HI: begin
					head_q     <= add_sum;
					rd_off_q   <= '0;
					res_drop_q <= 1'b1;
					state_q    <= S_EV_CHECK;
				end
				// write the header one byte a cycle
				S_HDR: begin
					k_q <= k_q + KW'(1);
					if (k_q == HDR_END_K) begin
						state_q <= S_HDR_END;
					end
				end
				S_HDR_END: begin
					fill_q <= add_sum;
					pend_q <= len_q;
					if (len_q == '0) begin
						commit_q <= add_sum;
						open_q   <= 1'b0;
					end else begin
						open_q <= 1'b1;
					end
					state_q <= S_FINISH;
				end
				// fetch header of the oldest record, then its next byte
				S_RD_T: begin
					res_type_q <= rd_data_q;
					state_q    <= S_RD_L;
				end
				S_RD_L: begin
					lenlo_q <= rd_data_q;
					state_q <= S_RD_H;
				end
				S_RD_H: begin
					res_len_q <= len_ev;
					state_q   <= S_RD_D;
				end
				S_RD_D: begin
					if (rd_more) begin
						res_byte_q <= rd_data_q;
					end
					if (off_next >= res_len_q) begin
						head_q     <= add_sum;
						rd_off_q   <= '0;
						res_last_q <= 1'b1;
					end else begin
						rd_off_q <= off_next;
					end
					state_q <= S_FINISH;
				end
				// hand the result to the output register when it is free
				S_FINISH: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						status_q    <= res_status_q;
						out_byte_q  <= res_byte_q;
						out_type_q  <= res_type_q;
						out_len_q   <= res_len_q;
						out_last_q  <= res_last_q;
						dropped_q   <= res_drop_q;
						is_empty_q  <= (head_q == commit_q);
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign out_byte  = out_byte_q;
	assign out_type  = out_type_q;
	assign out_len   = out_len_q;
	assign out_last  = out_last_q;
	assign dropped   = dropped_q;
	assign is_empty  = is_empty_q;

endmodule

>>> sim/record_ring_buffer_drop_oldest_tb.sv
// Testbench for the record ring buffer: directed, eviction and random traffic against a ring model.
module record_ring_buffer_drop_oldest_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RING_DEPTH     = 4096;
	localparam int PTR_W          = $clog2(RING_DEPTH);
	localparam int LEN_BYTES      = rrb_pkg::HDR_BYTES - 1;
	localparam int RANDOM_WORDS   = 650;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int TAIL_CYCLES    = 64;

	typedef logic [PTR_W-1:0]              ring_ptr_t;
	typedef logic [rrb_pkg::ACT_W-1:0]     act_t;
	typedef logic [rrb_pkg::STAT_W-1:0]    stat_t;
	typedef logic [rrb_pkg::BYTE_W-1:0]    byte_t;
	typedef logic [rrb_pkg::LEN_W-1:0]     len_t;
	typedef logic [rrb_pkg::OFF_W-1:0]     off_t;

	// action code that the block leaves unassigned
	localparam act_t ACT_UNASSIGNED = act_t'(3);

	// one result word as the block reports it
	typedef struct {
		stat_t status;
		byte_t data;
		byte_t rtype;
		len_t  length;
		logic  last;
		logic  drop;
		logic  empty;
	} ring_word_t;

	logic  clk       = 1'b0;
	logic  arst_n    = 1'b0;
	logic  in_valid  = 1'b0;
	logic  in_ready;
	act_t  action    = '0;
	byte_t rec_type  = '0;
	len_t  rec_len   = '0;
	byte_t data_byte = '0;
	logic  out_valid;
	logic  out_ready = 1'b0;
	stat_t status;
	byte_t out_byte;
	byte_t out_type;
	len_t  out_len;
	logic  out_last;
	logic  dropped;
	logic  is_empty;

	// ring model state
	byte_t     ring_mem [RING_DEPTH];
	ring_ptr_t ring_commit;
	ring_ptr_t ring_fill;
	ring_ptr_t ring_head;
	off_t      ring_rd_off;
	off_t      ring_pending;
	logic      ring_open;

	ring_word_t expected_words [$];
	int words_sent   = 0;
	int fail_count   = 0;
	int burst_left   = 0;
	int idle_cycles  = 0;
	int stall_mode   = 0;
	int stall_left   = 0;
	int stall_phase  = 0;

	record_ring_buffer_drop_oldest #(
		.DEPTH(RING_DEPTH)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.rec_type  (rec_type),
		.rec_len   (rec_len),
		.data_byte (data_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.out_byte  (out_byte),
		.out_type  (out_type),
		.out_len   (out_len),
		.out_last  (out_last),
		.dropped   (dropped),
		.is_empty  (is_empty)
	);

	always #4 clk = ~clk;

	// ---------------------------------------------------------------- ring model

	function automatic ring_ptr_t ring_add(input ring_ptr_t p, input int n);
		int s;
		s = (int'(p) + n) % RING_DEPTH;
		return s[PTR_W-1:0];
	endfunction

	// length field of the header at p, little-endian
	function automatic int hdr_len(input ring_ptr_t p);
		logic [31:0] v;
		int i;
		v = '0;
		for (i = LEN_BYTES - 1; i >= 0; i--) begin
			v = {v[23:0], ring_mem[ring_add(p, 1 + i)]};
		end
		return int'(v[rrb_pkg::LEN_W-1:0]);
	endfunction

	function automatic int ring_used();
		return (int'(ring_commit) + RING_DEPTH - int'(ring_head)) % RING_DEPTH;
	endfunction

	// drop the oldest record
	function automatic void ring_pop();
		ring_head   = ring_add(ring_head, rrb_pkg::HDR_BYTES + hdr_len(ring_head));
		ring_rd_off = '0;
	endfunction

	// advance the ring model by one accepted word and return the result it owes
	function automatic ring_word_t ring_model_step(input act_t act, input byte_t typ,
			input len_t len, input byte_t dat);
		ring_word_t  r;
		int          total;
		int          olen;
		int          i;
		logic [31:0] len32;
		r.status = rrb_pkg::ST_OK;
		r.data   = '0;
		r.rtype  = '0;
		r.length = '0;
		r.last   = 1'b0;
		r.drop   = 1'b0;
		len32    = {20'd0, len};
		case (act)
			rrb_pkg::ACT_BEGIN: begin
				total = rrb_pkg::HDR_BYTES + int'(len);
				if (ring_open) begin
					r.status = rrb_pkg::ST_BAD_STATE;
				end else if (total + 1 >= RING_DEPTH) begin
					r.status = rrb_pkg::ST_TOO_LARGE;
				end else begin
					// evict whole oldest records until the new one fits
					while (ring_head != ring_commit &&
					       ring_used() + total + 1 >= RING_DEPTH) begin
						ring_pop();
						r.drop = 1'b1;
					end
					ring_mem[ring_commit] = typ;
					for (i = 0; i < LEN_BYTES; i++) begin
						ring_mem[ring_add(ring_commit, 1 + i)] = len32[8*i +: 8];
					end
					ring_fill    = ring_add(ring_commit, rrb_pkg::HDR_BYTES);
					ring_pending = {1'b0, len};
					if (len == '0) begin
						ring_commit = ring_fill;
						ring_open   = 1'b0;
					end else begin
						ring_open = 1'b1;
					end
				end
			end
			rrb_pkg::ACT_WRITE: begin
				if (!ring_open) begin
					r.status = rrb_pkg::ST_BAD_STATE;
				end else begin
					ring_mem[ring_fill] = dat;
					ring_fill    = ring_add(ring_fill, 1);
					ring_pending = ring_pending - off_t'(1);
					if (ring_pending == '0) begin
						ring_commit = ring_fill;
						ring_open   = 1'b0;
					end
				end
			end
			rrb_pkg::ACT_READ: begin
				if (ring_head == ring_commit) begin
					r.status = rrb_pkg::ST_EMPTY;
				end else begin
					r.rtype  = ring_mem[ring_head];
					olen     = hdr_len(ring_head);
					r.length = olen[rrb_pkg::LEN_W-1:0];
					if (int'(ring_rd_off) < olen) begin
						r.data      = ring_mem[ring_add(ring_head,
						                       rrb_pkg::HDR_BYTES + int'(ring_rd_off))];
						ring_rd_off = ring_rd_off + off_t'(1);
					end
					if (int'(ring_rd_off) >= olen) begin
						ring_pop();
						r.last = 1'b1;
					end
				end
			end
			default: begin
				r.status = rrb_pkg::ST_BAD_STATE;
			end
		endcase
		r.empty = (ring_head == ring_commit);
		return r;
	endfunction

	// ---------------------------------------------------------------- sender

	// drive one word, wait for it to be taken, then record what it owes
	task automatic send_word(input act_t act, input byte_t typ, input len_t len,
			input byte_t dat);
		ring_word_t w;
		// insert a gap between bursts
		if (burst_left <= 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
			                                         : $urandom_range(1, 24);
		end
		burst_left--;
		in_valid  <= 1'b1;
		action    <= act;
		rec_type  <= typ;
		rec_len   <= len;
		data_byte <= dat;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		w = ring_model_step(act, typ, len, dat);
		expected_words.insert(expected_words.size(), w);
		words_sent++;
	endtask

	// send a word whose unused fields are random
	task automatic send_op(input act_t act);
		send_word(act, byte_t'($urandom_range(0, 255)), len_t'($urandom_range(0, 4095)),
		          byte_t'($urandom_range(0, 255)));
	endtask

	task automatic read_bytes(input int n);
		repeat (n) send_op(rrb_pkg::ACT_READ);
	endtask

	// begin a record, then fill it, mixing in reads now and then
	task automatic send_record(input int len, input int read_pct);
		send_word(rrb_pkg::ACT_BEGIN, byte_t'($urandom_range(0, 255)), len_t'(len),
		          byte_t'($urandom_range(0, 255)));
		while (ring_open) begin
			if ($urandom_range(0, 99) < read_pct) begin
				send_op(rrb_pkg::ACT_READ);
			end else begin
				send_op(rrb_pkg::ACT_WRITE);
			end
		end
	endtask

	// hold the sender until every owed result has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_words.size() != 0) @(posedge clk);
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_directed();
		// empty, no open record, unassigned action
		send_op(rrb_pkg::ACT_READ);
		send_word(rrb_pkg::ACT_WRITE, 8'h00, 12'h000, 8'hFF);
		send_word(ACT_UNASSIGNED, 8'hFF, 12'hFFF, 8'hFF);
		// too large, at the limit and at full width
		send_word(rrb_pkg::ACT_BEGIN, 8'h00, 12'd4090, 8'h00);
		send_word(rrb_pkg::ACT_BEGIN, 8'hFF, 12'hFFF, 8'hFF);
		// zero-length record commits at its begin
		send_word(rrb_pkg::ACT_BEGIN, 8'h3C, 12'd0, 8'h00);
		send_op(rrb_pkg::ACT_READ);
		// reads see only committed records; begin while open is refused
		send_word(rrb_pkg::ACT_BEGIN, 8'hA5, 12'd3, 8'h00);
		send_op(rrb_pkg::ACT_READ);
		send_word(rrb_pkg::ACT_BEGIN, 8'h11, 12'd1, 8'h00);
		send_word(rrb_pkg::ACT_WRITE, 8'h00, 12'h000, 8'h00);
		send_word(rrb_pkg::ACT_WRITE, 8'hFF, 12'hFFF, 8'hFF);
		send_word(rrb_pkg::ACT_WRITE, 8'h00, 12'h000, 8'h5A);
		send_word(ACT_UNASSIGNED, 8'h00, 12'h000, 8'h00);
		read_bytes(4);
		wait_drained();
		// a zero-length record followed by another record
		send_word(rrb_pkg::ACT_BEGIN, 8'hFF, 12'd0, 8'h00);
		send_word(rrb_pkg::ACT_BEGIN, 8'h01, 12'd2, 8'h00);
		send_word(rrb_pkg::ACT_WRITE, 8'h00, 12'h000, 8'h81);
		send_word(rrb_pkg::ACT_WRITE, 8'h00, 12'h000, 8'h7E);
		read_bytes(4);
	endtask

	task automatic test_eviction();
		// a partly read record is dropped whole; the next one reads from its start
		send_record(8, 0);
		send_record(30, 0);
		read_bytes(4);
		// pack the ring with empty records until the next begin must evict the oldest
		while (ring_used() + rrb_pkg::HDR_BYTES + 300 + 1 < RING_DEPTH) begin
			send_record(0, 0);
		end
		send_record(300, 0);
		read_bytes(31);
		wait_drained();
		// one begin that evicts several records at once
		send_record(60, 5);
		read_bytes(3);
	endtask

	task automatic test_random_traffic();
		int   start;
		int   pick;
		int   len;
		bit   paused;
		act_t act;
		start  = words_sent;
		paused = 1'b0;
		while (words_sent - start < RANDOM_WORDS) begin
			if (!paused && words_sent - start >= RANDOM_WORDS / 2) begin
				wait_drained();
				paused = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				pick = $urandom_range(0, 99);
				len = (pick < 60) ? $urandom_range(0, 15) :
				      (pick < 85) ? $urandom_range(16, 127) : $urandom_range(128, 700);
				send_record(len, 20);
			end else if (pick < 85) begin
				read_bytes($urandom_range(1, 40));
			end else begin
				// noise: any action, stray writes, begins of which some are refused
				act = act_t'($urandom_range(0, 3));
				if (act == rrb_pkg::ACT_BEGIN && !ring_open) begin
					len = ($urandom_range(0, 1) == 0) ? $urandom_range(4090, 4095)
					                                  : $urandom_range(0, 15);
					send_word(act, byte_t'($urandom_range(0, 255)), len_t'(len),
					          byte_t'($urandom_range(0, 255)));
				end else begin
					send_op(act);
				end
			end
		end
	endtask

	// ---------------------------------------------------------------- receiver

	// stall the result channel on a changing pattern
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(32, 256);
		end else begin
			stall_left <= stall_left - 1;
		end
		stall_phase <= stall_phase + 1;
		case (stall_mode)
			0: begin
				out_ready <= 1'b1;
			end
			1: begin
				out_ready <= ($urandom_range(0, 3) != 0);
			end
			2: begin
				out_ready <= (stall_phase % 5) < 2;
			end
			default: begin
				out_ready <= ($urandom_range(0, 7) == 0);
			end
		endcase
	end

	// ---------------------------------------------------------------- checker

	function automatic void check_field(input string name, input logic [31:0] expv,
			input logic [31:0] actv);
		if (actv !== expv) begin
			$error("%s: expected %0d, got %0d", name, expv, actv);
			fail_count++;
		end
	endfunction

	// compare each taken result with the oldest owed one
	always @(posedge clk) begin
		ring_word_t w;
		if (arst_n && out_valid && out_ready) begin
			if (expected_words.size() == 0) begin
				$error("result word with nothing owed");
				fail_count++;
			end else begin
				w = expected_words.pop_front();
				check_field("status", 32'(w.status), 32'(status));
				check_field("out_byte", 32'(w.data), 32'(out_byte));
				check_field("out_type", 32'(w.rtype), 32'(out_type));
				check_field("out_len", 32'(w.length), 32'(out_len));
				check_field("out_last", 32'(w.last), 32'(out_last));
				check_field("dropped", 32'(w.drop), 32'(dropped));
				check_field("is_empty", 32'(w.empty), 32'(is_empty));
			end
		end
	end

	// end the run when neither channel moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		foreach (ring_mem[i]) ring_mem[i] = '0;
		ring_commit  = '0;
		ring_fill    = '0;
		ring_head    = '0;
		ring_rd_off  = '0;
		ring_pending = '0;
		ring_open    = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_eviction();
		test_random_traffic();
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
